@@ design/dfs_ts_pkg.sv @@
// shared types and constants for the depth-first topological sort block
package dfs_ts_pkg;

   localparam int VERTEX_W = 6;
   localparam int REQ_W    = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RUN   = 2'd2;

   localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 6'd32;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [VERTEX_W-1:0] src_vertex;
      logic [VERTEX_W-1:0] dst_vertex;
   } req_payload_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] topo_vertex;
      logic                last_of_run;
   } rsp_payload_type;

endpackage

@@ design/dfs_ts_if.sv @@
// valid/ready channel interfaces for requests, results and the vertex count register
interface dfs_ts_req_if;
   logic                        valid;
   logic                        ready;
   dfs_ts_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dfs_ts_rsp_if;
   logic                        valid;
   logic                        ready;
   dfs_ts_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dfs_ts_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dfs_ts_pkg::VERTEX_W-1:0]     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/dfs_ts_ffs.sv @@
// find-first-set: index of the lowest set bit, by halving the window
module dfs_ts_ffs #(
   parameter int W = 32
) (
   input  logic [W-1:0]         vec,
   output logic                 found,
   output logic [$clog2(W)-1:0] idx
);

   localparam int IW = $clog2(W);
   localparam int P  = 1 << IW;

   always_comb begin
      logic [P-1:0] w;
      w   = P'(vec);
      idx = '0;
      for (int b = IW - 1; b >= 0; b--) begin
         // lower half empty: the first set bit lies in the upper half
         if (~|(w & ((P'(1) << (1 << b)) - P'(1)))) begin
            idx[b] = 1'b1;
            w      = w >> (1 << b);
         end
      end
      found = |vec;
   end

endmodule

@@ design/dfs_topological_sort_top.sv @@
// depth-first topological sort over an adjacency bit matrix held in memory
//
//  channel  dir  handshake               carries
//  req_ch   in   valid/ready             req_type, src_vertex, dst_vertex
//  rsp_ch   out  valid/ready             topo_vertex, last_of_run
//  csr_ch   in   valid/ready (always 1)  vertex_count
//
// clear drops the row valid flags; add edge reads the row, then writes it back.
// a run takes one root search per tree, a row read and neighbour scan
// for every push and every finish, and a stack read per resume, through the
// one-port adjacency and stack memories.
// results then leave one at a time through the post-order memory port.
// reset is synchronous; the graph reads as empty after reset through per-row
// valid flags, so no clearing pass is needed. the last result of a run may
// stall in its register while the next request is already taken.
module dfs_topological_sort_top #(
   parameter int VERTEX_SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   dfs_ts_req_if.sink        req_ch,
   dfs_ts_rsp_if.source      rsp_ch,
   dfs_ts_csr_if.sink        csr_ch
);

   localparam int VW = $clog2(VERTEX_SLOTS);
   localparam int NW = $clog2(VERTEX_SLOTS + 1);
   localparam int XW = dfs_ts_pkg::VERTEX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_ROOT,
      ST_ROW,
      ST_SCAN,
      ST_POP_RD,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [XW-1:0]           vcount_ff;
   logic [VERTEX_SLOTS-1:0] row_valid_ff;
   logic [VERTEX_SLOTS-1:0] visited_ff;
   logic [VERTEX_SLOTS-1:0] cand_ff;
   logic [VW-1:0]           top_v_ff;
   logic [NW-1:0]           top_c_ff;
   logic [NW-1:0]           depth_ff;
   logic [NW-1:0]           pcount_ff;
   logic [NW-1:0]           out_idx_ff;
   logic                    pend_ff;
   logic                    rsp_valid_ff;
   dfs_ts_pkg::rsp_payload_type rsp_data_ff;
   logic [VW-1:0]           add_idx_ff;
   logic [VERTEX_SLOTS-1:0] add_bit_ff;
   logic                    edge_ok_ff;

   // memories and their registered read data
   logic [VERTEX_SLOTS-1:0] adj_mem  [VERTEX_SLOTS];
   logic [VW-1:0]           vstk_mem [VERTEX_SLOTS];
   logic [NW-1:0]           cstk_mem [VERTEX_SLOTS];
   logic [VW-1:0]           post_mem [VERTEX_SLOTS];
   logic [VERTEX_SLOTS-1:0] adj_rd_ff;
   logic                    rowv_ff;
   logic [VW-1:0]           vstk_rd_ff;
   logic [NW-1:0]           cstk_rd_ff;
   logic [VW-1:0]           post_rd_ff;

   logic [NW-1:0]           n_eff;
   logic [VERTEX_SLOTS-1:0] nmask;
   logic [VERTEX_SLOTS-1:0] cmask;
   logic [VERTEX_SLOTS-1:0] row_word;
   logic [VERTEX_SLOTS-1:0] cand_in;
   logic [VERTEX_SLOTS-1:0] ffs_vec;
   logic                    ffs_found;
   logic [VW-1:0]           ffs_idx;
   logic [VW-1:0]           adj_raddr;
   logic [VW-1:0]           stk_raddr;
   logic [VW-1:0]           stk_waddr;
   logic [VW-1:0]           post_raddr;
   logic                    edge_ok;
   logic                    req_fire;
   logic                    rsp_fire;
   logic                    push;
   logic                    pop;
   logic                    out_issue;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_valid_ff && rsp_ch.ready;

   // a count above the storage acts as the full storage
   assign n_eff = (int'(vcount_ff) > VERTEX_SLOTS) ? NW'(VERTEX_SLOTS) : NW'(vcount_ff);

   assign edge_ok = (req_ch.data.src_vertex != '0) && (req_ch.data.dst_vertex != '0)
                    && (int'(req_ch.data.src_vertex) <= int'(n_eff))
                    && (int'(req_ch.data.dst_vertex) <= int'(n_eff));

   always_comb begin
      for (int i = 0; i < VERTEX_SLOTS; i++) begin
         nmask[i] = (NW'(i) < n_eff);
         cmask[i] = (NW'(i) >= top_c_ff);
      end
   end

   assign row_word = rowv_ff ? adj_rd_ff : '0;
   assign cand_in  = row_word & ~visited_ff & nmask & cmask;
   assign ffs_vec  = (state_ff == ST_ROOT) ? (~visited_ff & nmask) : cand_ff;

   dfs_ts_ffs #(
      .W (VERTEX_SLOTS)
   ) u_ffs (
      .vec   (ffs_vec),
      .found (ffs_found),
      .idx   (ffs_idx)
   );

   assign push      = (state_ff == ST_SCAN) && ffs_found;
   assign pop       = (state_ff == ST_SCAN) && !ffs_found;
   assign out_issue = (state_ff == ST_OUT) && !pend_ff && (out_idx_ff != pcount_ff)
                      && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      case (state_ff)
         ST_IDLE:   adj_raddr = VW'(req_ch.data.src_vertex - XW'(1));
         ST_POP_RD: adj_raddr = vstk_rd_ff;
         default:   adj_raddr = ffs_idx;
      endcase
   end

   assign stk_waddr  = VW'(depth_ff - NW'(1));
   assign stk_raddr  = VW'(depth_ff - NW'(2));
   assign post_raddr = VW'(pcount_ff - out_idx_ff - NW'(1));

   // adjacency rows: read every cycle, written back on an add edge with valid vertices
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD_WR && edge_ok_ff) begin
         adj_mem[add_idx_ff] <= (rowv_ff ? adj_rd_ff : '0) | add_bit_ff;
      end
      adj_rd_ff <= adj_mem[adj_raddr];
      rowv_ff   <= row_valid_ff[adj_raddr];
   end

   // stack below the top entry; the top lives in top_v_ff/top_c_ff
   always_ff @(posedge clock) begin
      if (push) begin
         vstk_mem[stk_waddr] <= top_v_ff;
         cstk_mem[stk_waddr] <= NW'(ffs_idx) + NW'(1);
      end
      vstk_rd_ff <= vstk_mem[stk_raddr];
      cstk_rd_ff <= cstk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         post_mem[VW'(pcount_ff)] <= top_v_ff;
      end
      post_rd_ff <= post_mem[post_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= dfs_ts_pkg::VERTEX_COUNT_RESET;
         row_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         pcount_ff    <= '0;
         out_idx_ff   <= '0;
      end else begin
         if (csr_ch.valid) begin
            vcount_ff <= csr_ch.data;
         end

         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pend_ff) begin
            pend_ff                 <= 1'b0;
            rsp_valid_ff            <= 1'b1;
            rsp_data_ff.topo_vertex <= XW'({1'b0, post_rd_ff} + (VW + 1)'(1));
            rsp_data_ff.last_of_run <= (out_idx_ff == pcount_ff);
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_ch.data.req_type)
                     dfs_ts_pkg::REQ_CLEAR: begin
                        row_valid_ff <= '0;
                     end
                     dfs_ts_pkg::REQ_ADD: begin
                        add_idx_ff <= VW'(req_ch.data.src_vertex - XW'(1));
                        add_bit_ff <= VERTEX_SLOTS'(1)
                                      << VW'(req_ch.data.dst_vertex - XW'(1));
                        edge_ok_ff <= edge_ok;
                        state_ff   <= ST_ADD_WR;
                     end
                     dfs_ts_pkg::REQ_RUN: begin
                        visited_ff <= '0;
                        depth_ff   <= '0;
                        pcount_ff  <= '0;
                        out_idx_ff <= '0;
                        state_ff   <= ST_ROOT;
                     end
                     default: ;
                  endcase
               end
            end
            ST_ADD_WR: begin
               if (edge_ok_ff) begin
                  row_valid_ff[add_idx_ff] <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            ST_ROOT: begin
               // lowest unvisited vertex starts the next tree
               if (ffs_found) begin
                  visited_ff[ffs_idx] <= 1'b1;
                  top_v_ff            <= ffs_idx;
                  top_c_ff            <= '0;
                  depth_ff            <= NW'(1);
                  state_ff            <= ST_ROW;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_ROW: begin
               cand_ff  <= cand_in;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (ffs_found) begin
                  visited_ff[ffs_idx] <= 1'b1;
                  top_v_ff            <= ffs_idx;
                  top_c_ff            <= '0;
                  depth_ff            <= depth_ff + NW'(1);
                  state_ff            <= ST_ROW;
               end else begin
                  pcount_ff <= pcount_ff + NW'(1);
                  depth_ff  <= depth_ff - NW'(1);
                  if (depth_ff == NW'(1)) begin
                     state_ff <= ST_ROOT;
                  end else begin
                     state_ff <= ST_POP_RD;
                  end
               end
            end
            ST_POP_RD: begin
               top_v_ff <= vstk_rd_ff;
               top_c_ff <= cstk_rd_ff;
               state_ff <= ST_ROW;
            end
            ST_OUT: begin
               if (out_issue) begin
                  pend_ff    <= 1'b1;
                  out_idx_ff <= out_idx_ff + NW'(1);
               end else if (!pend_ff && out_idx_ff == pcount_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/dfs_ts_checker.sv @@
// port-level checks on the topological sort block, bound to the top level
module dfs_ts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [dfs_ts_pkg::REQ_W-1:0]      req_type,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dfs_ts_pkg::VERTEX_W-1:0]   topo_vertex,
   input logic                              last_of_run
);

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(topo_vertex) && $stable(last_of_run))
      else $error("result changed while stalled");

   // add edge and run both keep the block busy for the following cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready
      && (req_type == dfs_ts_pkg::REQ_ADD || req_type == dfs_ts_pkg::REQ_RUN)
      |=> !req_ready)
      else $error("request taken while previous one still in progress");

   // vertices are numbered from one
   a_vertex_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> topo_vertex != '0)
      else $error("vertex zero emitted");

   // a run is still emitting until its last result has gone
   a_run_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_run |=> !req_ready)
      else $error("request side reopened before the last result");

endmodule

bind dfs_topological_sort_top dfs_ts_checker u_dfs_ts_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_type    (req_ch.data.req_type),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .topo_vertex (rsp_ch.data.topo_vertex),
   .last_of_run (rsp_ch.data.last_of_run)
);
